### design/bvp_pkg.sv
// ----------------------------------------------------------------------------
// bvp_pkg: shared types and constants for the battery charge converter
// Voltage table, per-segment reciprocals and the stage payload structs.
// ----------------------------------------------------------------------------
package bvp_pkg;

  localparam int unsigned NumPoints = 11;
  localparam int unsigned NumSegs   = NumPoints - 1;
  localparam int unsigned RecipShift = 25;

  localparam logic [9:0] ChargeMax = 10'd999;

  localparam logic [15:0] VOLT_TABLE [NumPoints] = '{
    16'd3220, 16'd3680, 16'd3740, 16'd3770, 16'd3790, 16'd3820,
    16'd3870, 16'd3920, 16'd3980, 16'd4060, 16'd4200
  };

  localparam int unsigned SEG_W [NumSegs] = '{
    460, 60, 30, 20, 30, 50, 50, 60, 80, 140
  };

  // ceil(2^25 / width): exact floor division for any numerator below 2^16.
  localparam logic [20:0] SEG_RECIP [NumSegs] = '{
    21'(((64'd1 << RecipShift) + SEG_W[0] - 1) / SEG_W[0]),
    21'(((64'd1 << RecipShift) + SEG_W[1] - 1) / SEG_W[1]),
    21'(((64'd1 << RecipShift) + SEG_W[2] - 1) / SEG_W[2]),
    21'(((64'd1 << RecipShift) + SEG_W[3] - 1) / SEG_W[3]),
    21'(((64'd1 << RecipShift) + SEG_W[4] - 1) / SEG_W[4]),
    21'(((64'd1 << RecipShift) + SEG_W[5] - 1) / SEG_W[5]),
    21'(((64'd1 << RecipShift) + SEG_W[6] - 1) / SEG_W[6]),
    21'(((64'd1 << RecipShift) + SEG_W[7] - 1) / SEG_W[7]),
    21'(((64'd1 << RecipShift) + SEG_W[8] - 1) / SEG_W[8]),
    21'(((64'd1 << RecipShift) + SEG_W[9] - 1) / SEG_W[9])
  };

  typedef struct packed {
    logic [3:0] seg;
    logic [8:0] off;
    logic       below;
    logic       above;
  } seg_t;

  typedef struct packed {
    logic [3:0] seg;
    logic [6:0] quo;
    logic       below;
    logic       above;
  } quo_t;

endpackage

### design/bvp_seg.sv
// ----------------------------------------------------------------------------
// bvp_seg: segment search stage
// Finds the table segment of the voltage and its offset from the segment start.
// ----------------------------------------------------------------------------
module bvp_seg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [15:0]   voltage_mv_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output bvp_pkg::seg_t out_data_o
);
  import bvp_pkg::*;

  logic       valid_q;
  seg_t       data_q, data_d;
  logic [8:0] ge;
  logic [3:0] seg;
  logic [15:0] diff;

  always_comb begin
    for (int i = 0; i < NumSegs - 1; i++) begin
      ge[i] = (voltage_mv_i >= VOLT_TABLE[i + 1]);
    end
    // The table is ascending, so the count of passed points is the segment.
    seg  = 4'($countones(ge));
    diff = voltage_mv_i - VOLT_TABLE[seg];
    data_d.below = (voltage_mv_i < VOLT_TABLE[0]);
    data_d.above = (voltage_mv_i >= VOLT_TABLE[NumPoints - 1]);
    data_d.seg   = seg;
    data_d.off   = (data_d.below || data_d.above) ? 9'd0 : diff[8:0];
  end

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

### design/bvp_div.sv
// ----------------------------------------------------------------------------
// bvp_div: scaled division by the segment width
// Two stages: scale the offset by 100 and fetch the reciprocal, then multiply.
// ----------------------------------------------------------------------------
module bvp_div (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  bvp_pkg::seg_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output bvp_pkg::quo_t out_data_o
);
  import bvp_pkg::*;

  logic        mul_valid_q;
  logic        mul_ready;
  logic [3:0]  mul_seg_q;
  logic        mul_below_q, mul_above_q;
  logic [15:0] num_q, num_d;
  logic [20:0] recip_q;

  logic        quo_valid_q;
  quo_t        quo_q;
  logic [36:0] prod;

  assign num_d = 16'(in_data_i.off) * 16'd100;

  assign mul_ready  = !quo_valid_q || out_ready_i;
  assign in_ready_o = !mul_valid_q || mul_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
      quo_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        mul_valid_q <= in_valid_i;
      end
      if (mul_ready) begin
        quo_valid_q <= mul_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      mul_seg_q   <= in_data_i.seg;
      mul_below_q <= in_data_i.below;
      mul_above_q <= in_data_i.above;
      num_q       <= num_d;
      recip_q     <= (in_data_i.seg < 4'(NumSegs)) ? SEG_RECIP[in_data_i.seg] : 21'd0;
    end
  end

  assign prod = 37'(num_q) * 37'(recip_q);

  always_ff @(posedge clk_i) begin
    if (mul_ready && mul_valid_q) begin
      quo_q.seg   <= mul_seg_q;
      quo_q.below <= mul_below_q;
      quo_q.above <= mul_above_q;
      // The quotient stays below 100, so the upper product bits are zero.
      quo_q.quo   <= prod[RecipShift +: 7];
    end
  end

  assign out_valid_o = quo_valid_q;
  assign out_data_o  = quo_q;

endmodule

### design/bvp_out.sv
// ----------------------------------------------------------------------------
// bvp_out: charge assembly and gauge stage
// Adds the segment base, applies the table limits and derives the icon level.
// ----------------------------------------------------------------------------
module bvp_out (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  bvp_pkg::quo_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [9:0]    charge_tenths_o,
  output logic [2:0]    gauge_level_o
);
  import bvp_pkg::*;

  logic       valid_q;
  logic [9:0] charge_q, charge_d, interp;
  logic [2:0] level_q, level_d;

  always_comb begin
    interp = 10'(in_data_i.seg) * 10'd100 + 10'(in_data_i.quo);
    if (in_data_i.below) begin
      charge_d = 10'd0;
    end else if (in_data_i.above || interp > ChargeMax) begin
      charge_d = ChargeMax;
    end else begin
      charge_d = interp;
    end
    if (charge_d >= 10'd900) begin
      level_d = 3'd5;
    end else if (charge_d >= 10'd700) begin
      level_d = 3'd4;
    end else if (charge_d >= 10'd500) begin
      level_d = 3'd3;
    end else if (charge_d >= 10'd300) begin
      level_d = 3'd2;
    end else if (charge_d >= 10'd100) begin
      level_d = 3'd1;
    end else begin
      level_d = 3'd0;
    end
  end

  assign in_ready_o      = !valid_q || out_ready_i;
  assign out_valid_o     = valid_q;
  assign charge_tenths_o = charge_q;
  assign gauge_level_o   = level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      charge_q <= charge_d;
      level_q  <= level_d;
    end
  end

`ifndef ASSERT_OFF
  a_charge_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> charge_q <= ChargeMax)
    else $error("charge above cap");
  a_level_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && charge_q >= 10'd900) |-> level_q == 3'd5)
    else $error("full charge without full gauge");
  a_level_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && charge_q < 10'd100) |-> level_q == 3'd0)
    else $error("low charge without empty gauge");
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !out_ready_i) |=> (valid_q && $stable(charge_q) && $stable(level_q)))
    else $error("result changed under stall");
`endif

endmodule

### design/battery_voltage_to_percent.sv
// ----------------------------------------------------------------------------
// battery_voltage_to_percent: battery voltage to state of charge
// Piecewise linear interpolation over an 11-point voltage table.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one item per voltage sample in millivolts
//   (voltage_mv_i, qualified by in_valid_i / in_ready_o). The output channel
//   returns one item per sample: the charge in tenths of a percent (0..999)
//   and a gauge level 0..5 (out_valid_o / out_ready_i).
//   The block is a four-stage pipeline: segment search, scaling with the
//   reciprocal lookup, the reciprocal multiply, and charge/gauge assembly.
//   One item is accepted every cycle until a receiver stall fills the
//   pipeline; the 16 x 21 bit reciprocal multiply sets the stage depth.
//   Every stage has its own valid bit and loads whenever it is
//   empty or its successor moves, so bubbles are squeezed out.
//   Reset clears all valid bits; the data registers are not reset.
//   While the receiver stalls, the result holds steady and the earlier
//   stages keep filling until the pipeline is full, then in_ready_o drops.
module battery_voltage_to_percent (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] voltage_mv_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [9:0]  charge_tenths_o,
  output logic [2:0]  gauge_level_o
);
  import bvp_pkg::*;

  logic seg_valid, seg_ready;
  seg_t seg_data;
  logic quo_valid, quo_ready;
  quo_t quo_data;

  bvp_seg u_seg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .voltage_mv_i (voltage_mv_i),
    .out_valid_o  (seg_valid),
    .out_ready_i  (seg_ready),
    .out_data_o   (seg_data)
  );

  bvp_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (seg_valid),
    .in_ready_o  (seg_ready),
    .in_data_i   (seg_data),
    .out_valid_o (quo_valid),
    .out_ready_i (quo_ready),
    .out_data_o  (quo_data)
  );

  bvp_out u_out (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (quo_valid),
    .in_ready_o      (quo_ready),
    .in_data_i       (quo_data),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .charge_tenths_o (charge_tenths_o),
    .gauge_level_o   (gauge_level_o)
  );

endmodule

### dv/battery_voltage_to_percent_tb.sv
// ----------------------------------------------------------------------------
// battery_voltage_to_percent_tb: self-checking bench for the charge converter
// Directed table corners, then random voltages focused on the table range.
// Every result is compared with an in-bench interpolation predictor. Both
// channels idle at random, and one long receiver stall fills the pipeline.
// ----------------------------------------------------------------------------
module battery_voltage_to_percent_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bvp_pkg::*;

  localparam int unsigned ClkPeriod   = 8;
  localparam int unsigned ResetCycles = 4;
  localparam int unsigned RandomItems = 1625;
  localparam int unsigned IdlePct     = 8;
  localparam int unsigned CalmFirst   = 700;
  localparam int unsigned CalmLast    = 1000;
  localparam int unsigned HoldStart   = 300;
  localparam int unsigned HoldCycles  = 64;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned TimeoutNs   = 2_000_000;

  typedef struct packed {
    logic [9:0] charge;
    logic [2:0] gauge;
  } soc_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [15:0] voltage_mv_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [9:0]  charge_tenths_o;
  logic [2:0]  gauge_level_o;

  logic [15:0] pending_mv[$];
  soc_t        expected_soc[$];

  int unsigned n_accepted = 0;
  int unsigned n_checked = 0;
  int unsigned n_errors = 0;
  int unsigned n_input_stalls = 0;
  int unsigned n_below = 0;
  int unsigned n_full = 0;
  int unsigned hold_count = 0;
  logic        hold_done = 1'b0;
  logic        hold_active;

  battery_voltage_to_percent dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .voltage_mv_i   (voltage_mv_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .charge_tenths_o(charge_tenths_o),
    .gauge_level_o  (gauge_level_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Linear interpolation inside the table segment that holds the voltage.
  function automatic logic [9:0] interp_charge(input logic [15:0] mv);
    int unsigned seg;
    int unsigned lo;
    int unsigned span;
    int unsigned charge;
    if (mv < VOLT_TABLE[0]) return '0;
    if (mv >= VOLT_TABLE[NumPoints-1]) return ChargeMax;
    seg = 0;
    for (int k = 1; k < NumPoints - 1; k++) begin
      if (mv >= VOLT_TABLE[k]) seg = k;
    end
    lo = VOLT_TABLE[seg];
    span = int'(VOLT_TABLE[seg+1]) - lo;
    charge = 100 * seg + (100 * (int'(mv) - lo)) / span;
    if (charge > ChargeMax) charge = ChargeMax;
    return charge[9:0];
  endfunction

  function automatic logic [2:0] gauge_of_charge(input logic [9:0] charge);
    int unsigned c;
    c = charge;
    if (c >= 900) return 3'd5;
    if (c < 100) return 3'd0;
    return 3'((c - 100) / 200 + 1);
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $realtime, what);
    n_errors++;
  endtask

  function automatic logic roll_idle();
    if (n_accepted >= CalmFirst && n_accepted < CalmLast) return 1'b0;
    return $urandom_range(99) < IdlePct;
  endfunction

  // The receiver holds off once for a long stretch so the pipeline fills.
  assign hold_active = (n_accepted >= HoldStart) && !hold_done;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_count <= 0;
      hold_done  <= 1'b0;
    end else if (hold_active) begin
      if (hold_count == HoldCycles - 1) hold_done <= 1'b1;
      hold_count <= hold_count + 1;
    end
  end

  // Sender: presents the next pending item once the current one is taken.
  always @(posedge clk_i or negedge rst_ni) begin
    soc_t soc;
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      voltage_mv_i <= '0;
    end else begin
      if (in_valid_i && !in_ready_o) n_input_stalls++;
      if (in_valid_i && in_ready_o) begin
        soc.charge = interp_charge(voltage_mv_i);
        soc.gauge  = gauge_of_charge(soc.charge);
        expected_soc.push_back(soc);
        n_accepted++;
        if (voltage_mv_i < VOLT_TABLE[0]) n_below++;
        if (voltage_mv_i >= VOLT_TABLE[NumPoints-1]) n_full++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_mv.size() != 0 && !roll_idle()) begin
          in_valid_i   <= 1'b1;
          voltage_mv_i <= pending_mv.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each accepted result against the oldest expectation.
  always @(posedge clk_i or negedge rst_ni) begin
    soc_t soc;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_soc.size() == 0) begin
          report_mismatch($sformatf("unexpected result charge=%0d gauge=%0d",
                                    charge_tenths_o, gauge_level_o));
        end else begin
          soc = expected_soc.pop_front();
          n_checked++;
          if (charge_tenths_o !== soc.charge)
            report_mismatch($sformatf("charge_tenths got %0d, want %0d",
                                      charge_tenths_o, soc.charge));
          if (gauge_level_o !== soc.gauge)
            report_mismatch($sformatf("gauge_level got %0d, want %0d",
                                      gauge_level_o, soc.gauge));
        end
      end
      out_ready_i <= !hold_active && !roll_idle();
    end
  end

  initial begin
    logic [15:0] mv;
    int unsigned pick;

    // Directed corners: field extremes, every table point and just below it,
    // the region under the table and the saturated region above it.
    pending_mv.push_back(16'd0);
    pending_mv.push_back(16'hFFFF);
    pending_mv.push_back(16'h8000);
    for (int k = 0; k < NumPoints; k++) begin
      pending_mv.push_back(VOLT_TABLE[k]);
      if (k > 0) pending_mv.push_back(VOLT_TABLE[k] - 16'd1);
    end
    pending_mv.push_back(VOLT_TABLE[0] - 16'd1);
    pending_mv.push_back(VOLT_TABLE[NumPoints-1] + 16'd1);

    // Most random voltages sit in and around the table; some span all bits.
    for (int n = 0; n < RandomItems; n++) begin
      pick = $urandom_range(99);
      if (pick < 65) begin
        mv = 16'($urandom_range(VOLT_TABLE[NumPoints-1] + 100, VOLT_TABLE[0] - 100));
      end else if (pick < 80) begin
        mv = VOLT_TABLE[$urandom_range(NumPoints - 1)] + 16'($urandom_range(4)) - 16'd2;
      end else begin
        mv = 16'($urandom);
      end
      pending_mv.push_back(mv);
    end

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_mv.size() != 0 || in_valid_i || expected_soc.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Converted %0d voltages (%0d below the table, %0d saturated),",
             n_accepted, n_below, n_full);
    $display("checked %0d results; the input stalled for %0d cycles under backpressure.",
             n_checked, n_input_stalls);
    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #(TimeoutNs * 1ns);
    $display("Timeout with %0d results still expected", expected_soc.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
